// File: rtl/core/cdt_enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_pkg
// Shared types, codes, constants and helper functions of the telecontrol
// frame encoder.
// ----------------------------------------------------------------------------
package cdt_enc_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_START_STATUS = 2'd0,
        OP_START_ANALOG = 2'd1,
        OP_STATUS_WORD  = 2'd2,
        OP_ANALOG_WORD  = 2'd3
    } t_op;

    // frame constants
    localparam logic [7:0]  SYNC_A         = 8'hEB;
    localparam logic [7:0]  SYNC_B         = 8'h90;
    localparam logic [7:0]  CTRL_BYTE      = 8'h71;
    localparam logic [7:0]  TYPE_STATUS    = 8'hF4;
    localparam logic [7:0]  TYPE_ANALOG    = 8'h61;
    localparam logic [7:0]  STATUS_FC_BASE = 8'hF0;
    localparam logic [7:0]  CRC_POLY       = 8'h07;
    localparam logic [7:0]  CRC_FINAL      = 8'hFF;
    localparam logic [15:0] NEG_MAG_MASK   = 16'h07FF;
    localparam logic [15:0] NEG_FLAG       = 16'h0800;
    localparam int          STATUS_PER_WORD = 32;

    // byte layout of one group
    localparam int          GRP_BYTES      = 11;
    localparam logic [3:0]  HDR_LAST_POS   = 4'd11;
    localparam logic [3:0]  WORD_LAST_POS  = 4'd5;
    localparam logic [3:0]  HDR_CRC_FIRST  = 4'd6;

    // one header or info word, check byte not included
    typedef struct packed {
        logic                           hdr;
        logic [GRP_BYTES-1:0][7:0]      bytes;
    } t_group;

    // crc-8 update over one byte, msb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // analog value coding: positive as is, negative as flag plus inverted magnitude
    function automatic logic [15:0] code_analog(input logic signed [16:0] v);
        logic [16:0] mag;
        mag = 17'(-v);
        if (!v[16]) begin
            return v[15:0];
        end else if (mag > 17'(NEG_MAG_MASK)) begin
            return NEG_FLAG;
        end else begin
            return NEG_FLAG | ({5'd0, ~mag[10:0]} & NEG_MAG_MASK);
        end
    endfunction

endpackage

// File: rtl/core/cdt_enc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_in_if
// Input item channel: operation, point count, status and analog data.
// ----------------------------------------------------------------------------
interface cdt_enc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [11:0]        point_count;
    logic [31:0]        status_bits;
    logic [31:0]        invert_mask;
    logic signed [16:0] analog_first;
    logic signed [16:0] analog_second;

    modport source (
        output valid, operation, point_count, status_bits, invert_mask,
               analog_first, analog_second,
        input  ready
    );
    modport sink (
        input  valid, operation, point_count, status_bits, invert_mask,
               analog_first, analog_second,
        output ready
    );
endinterface

// File: rtl/core/cdt_enc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_out_if
// Output byte channel: one frame byte per transfer with an end-of-run flag.
// ----------------------------------------------------------------------------
interface cdt_enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_in_run;

    modport source (
        output valid, frame_byte, last_in_run,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last_in_run,
        output ready
    );
endinterface

// File: rtl/core/cdt_enc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_cfg_if
// Configuration write channel carrying the station address.
// ----------------------------------------------------------------------------
interface cdt_enc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// File: rtl/core/cdt_frame_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_frame_encoder_core
// Cyclic telecontrol frame encoder with byte-serial output.
// ----------------------------------------------------------------------------
// A start item (status or analog) emits the 12-byte frame header, or nothing
// when its point count is zero; each word item emits one 6-byte info word.
// Output runs at one byte per cycle while the receiver is ready; the byte
// serializer sets that rate. An item is turned into its byte group and held
// in a group register, so the next item is taken while the previous group
// still drains; the check byte is accumulated one byte per transfer as the
// bytes go out. The station address is to be written on the configuration
// channel only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cdt_frame_encoder_core
    import cdt_enc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    cdt_enc_in_if.sink      i_in,
    cdt_enc_cfg_if.sink     i_cfg,
    cdt_enc_out_if.source   o_out
);

    logic   grp_valid;
    logic   grp_ready;
    t_group grp;

    // item decode and group assembly
    cdt_enc_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp       (grp)
    );

    // byte serializer with check byte
    cdt_enc_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .i_grp       (grp),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/cdt_enc_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_build
// Takes input items, tracks word index and remaining points, and assembles
// the header or info word bytes into a registered group.
// ----------------------------------------------------------------------------
module cdt_enc_build
    import cdt_enc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    cdt_enc_in_if.sink      i_in,
    cdt_enc_cfg_if.sink     i_cfg,
    output logic            o_grp_valid,
    input  logic            i_grp_ready,
    output t_group          o_grp
);

    logic [7:0]   r_station;
    logic [7:0]   r_word_index;
    logic [11:0]  r_points_left;
    logic         r_grp_valid;
    t_group       r_grp;

    logic [7:0]   n_word_index;
    logic [11:0]  n_points_left;
    logic         n_produce;
    t_group       n_grp;

    logic         in_xfer;
    logic [31:0]  keep_mask;
    logic [31:0]  status_word;
    logic [15:0]  an_first;
    logic [15:0]  an_second;
    logic [7:0]   status_count;
    logic [12:0]  analog_sum;

    // no transfer is taken while reset is held
    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && (!r_grp_valid || i_grp_ready);
    assign in_xfer     = i_in.valid && i_in.ready;

    // point mask and data coding
    always_comb begin
        for (int b = 0; b < STATUS_PER_WORD; b++) begin
            keep_mask[b] = (12'(b) < r_points_left);
        end
        status_word  = (i_in.status_bits ^ i_in.invert_mask) & keep_mask;
        an_first     = (r_points_left >= 12'd1) ? code_analog(i_in.analog_first)  : 16'd0;
        an_second    = (r_points_left >= 12'd2) ? code_analog(i_in.analog_second) : 16'd0;
        status_count = {1'b0, i_in.point_count[11:5]} + {7'd0, |i_in.point_count[4:0]};
        analog_sum   = {1'b0, i_in.point_count} + 13'd1;
    end

    // group assembly and state update
    always_comb begin
        n_word_index  = r_word_index;
        n_points_left = r_points_left;
        n_produce     = 1'b1;
        n_grp.hdr     = 1'b0;
        n_grp.bytes   = '0;
        unique case (t_op'(i_in.operation))
            OP_START_STATUS, OP_START_ANALOG: begin
                n_word_index   = 8'd0;
                n_points_left  = i_in.point_count;
                n_produce      = (i_in.point_count != 12'd0);
                n_grp.hdr      = 1'b1;
                n_grp.bytes[0] = SYNC_A;
                n_grp.bytes[1] = SYNC_B;
                n_grp.bytes[2] = SYNC_A;
                n_grp.bytes[3] = SYNC_B;
                n_grp.bytes[4] = SYNC_A;
                n_grp.bytes[5] = SYNC_B;
                n_grp.bytes[6] = CTRL_BYTE;
                if (t_op'(i_in.operation) == OP_START_STATUS) begin
                    n_grp.bytes[7] = TYPE_STATUS;
                    n_grp.bytes[8] = status_count;
                end else begin
                    n_grp.bytes[7] = TYPE_ANALOG;
                    n_grp.bytes[8] = analog_sum[8:1];
                end
                n_grp.bytes[9]  = r_station;
                n_grp.bytes[10] = 8'd0;
            end
            OP_STATUS_WORD: begin
                n_word_index   = r_word_index + 8'd1;
                n_points_left  = (r_points_left < 12'(STATUS_PER_WORD)) ? 12'd0
                               : r_points_left - 12'(STATUS_PER_WORD);
                n_grp.bytes[0] = STATUS_FC_BASE + r_word_index;
                n_grp.bytes[1] = status_word[7:0];
                n_grp.bytes[2] = status_word[15:8];
                n_grp.bytes[3] = status_word[23:16];
                n_grp.bytes[4] = status_word[31:24];
            end
            OP_ANALOG_WORD: begin
                n_word_index   = r_word_index + 8'd1;
                n_points_left  = (r_points_left < 12'd2) ? 12'd0 : r_points_left - 12'd2;
                n_grp.bytes[0] = r_word_index;
                n_grp.bytes[1] = an_first[7:0];
                n_grp.bytes[2] = an_first[15:8];
                n_grp.bytes[3] = an_second[7:0];
                n_grp.bytes[4] = an_second[15:8];
            end
            default: begin
                n_produce = 1'b0;
            end
        endcase
    end

    // state, configuration and group register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station     <= 8'd0;
            r_word_index  <= 8'd0;
            r_points_left <= 12'd0;
            r_grp_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_station <= i_cfg.data;
            end
            if (in_xfer) begin
                r_word_index  <= n_word_index;
                r_points_left <= n_points_left;
                r_grp_valid   <= n_produce;
            end else if (i_grp_ready) begin
                r_grp_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && n_produce) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp_valid = r_grp_valid;
    assign o_grp       = r_grp;

endmodule

// File: rtl/core/cdt_enc_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_enc_serial
// Sends one group out byte by byte, running the crc-8 over the covered bytes
// and appending the check byte as the last byte of the run.
// ----------------------------------------------------------------------------
module cdt_enc_serial
    import cdt_enc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_grp_valid,
    output logic            o_grp_ready,
    input  t_group          i_grp,
    cdt_enc_out_if.source   o_out
);

    logic         r_act_valid;
    t_group       r_act;
    logic [3:0]   r_idx;
    logic [7:0]   r_crc;

    logic         out_xfer;
    logic         is_last;
    logic         in_crc;
    logic [7:0]   data_byte;

    // position decode
    assign is_last   = (r_idx == (r_act.hdr ? HDR_LAST_POS : WORD_LAST_POS));
    assign in_crc    = !r_act.hdr || (r_idx >= HDR_CRC_FIRST);
    assign data_byte = r_act.bytes[r_idx];
    assign out_xfer  = o_out.valid && o_out.ready;

    assign o_grp_ready       = !r_act_valid || (out_xfer && is_last);
    assign o_out.valid       = r_act_valid;
    assign o_out.frame_byte  = is_last ? (r_crc ^ CRC_FINAL) : data_byte;
    assign o_out.last_in_run = is_last;

    // control: group load and byte advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
        end else if (o_grp_ready) begin
            r_act_valid <= i_grp_valid;
        end
    end

    // payload: group, byte position and running check
    always_ff @(posedge i_clk) begin
        if (o_grp_ready && i_grp_valid) begin
            r_act <= i_grp;
            r_idx <= 4'd0;
            r_crc <= 8'd0;
        end else if (out_xfer) begin
            r_idx <= r_idx + 4'd1;
            if (in_crc) begin
                r_crc <= crc8_update(r_crc, data_byte);
            end
        end
    end

endmodule

// File: verif/cdt_frame_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_frame_encoder_core_tb
// Self-checking testbench for the telecontrol frame encoder. A directed table
// covers the frame headers, word coding, masking past the point count and the
// analog saturation edges, then randomized frame sequences with noise run
// under random stalls on both channels and several station addresses. Every
// output byte is checked against an in-bench frame predictor.
// ----------------------------------------------------------------------------
module cdt_frame_encoder_core_tb;
    import cdt_enc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 48;
    localparam int LONG_WORDS    = 258;
    localparam int N_PHASES      = 5;
    localparam int PRINT_LIMIT   = 50;

    // one input item
    typedef struct packed {
        t_op                op;
        logic [11:0]        count;
        logic [31:0]        bits;
        logic [31:0]        mask;
        logic signed [16:0] first;
        logic signed [16:0] second;
    } t_item;

    // one expected output byte
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_exp_byte;

    // directed row: item, plus the five crc-covered bytes where typed in
    typedef struct packed {
        t_item       it;
        logic        typed;
        logic [39:0] body;
    } t_row;

    localparam int N_DIRECTED = 23;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // words before any start carry zero data
        '{'{OP_STATUS_WORD, 12'd0, 32'hFFFF_FFFF, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'hF0_00_00_00_00},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd100, -17'sd5},
          1'b1, 40'h01_00_00_00_00},
        // zero point count emits nothing and clears the index
        '{'{OP_START_STATUS, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b0, 40'h00_00_00_00_00},
        // status frame of 40 points, then masking of the tail and past the count
        '{'{OP_START_STATUS, 12'd40, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_F4_02_00_00},
        '{'{OP_STATUS_WORD, 12'd0, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 17'sd0, 17'sd0},
          1'b1, 40'hF0_F0_F0_F0_F0},
        '{'{OP_STATUS_WORD, 12'd0, 32'h0000_0000, 32'hFFFF_FFFF, 17'sd0, 17'sd0},
          1'b1, 40'hF1_FF_00_00_00},
        '{'{OP_STATUS_WORD, 12'd0, 32'hAAAA_5555, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'hF2_00_00_00_00},
        // analog frame of 3 points: second value of the last word dropped
        '{'{OP_START_ANALOG, 12'd3, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_61_02_00_00},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd65535, -17'sd1},
          1'b1, 40'h00_FF_FF_FE_0F},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, -17'sd2047, 17'sd123},
          1'b1, 40'h01_00_08_00_00},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, -17'sd65535, 17'h1_0000},
          1'b1, 40'h02_00_00_00_00},
        // largest analog frame: word count wraps to its low byte
        '{'{OP_START_ANALOG, 12'd4095, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_61_00_00_00},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, -17'sd2048, 17'h1_0000},
          1'b1, 40'h00_00_08_00_08},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd0, -17'sd65535},
          1'b1, 40'h01_00_00_00_08},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd32767, -17'sd1024},
          1'b1, 40'h02_FF_7F_FF_0B},
        // largest status frame, then a word of the other type inside it
        '{'{OP_START_STATUS, 12'd4095, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_F4_80_00_00},
        '{'{OP_STATUS_WORD, 12'd0, 32'h1234_5678, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'hF0_78_56_34_12},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd1, 17'sd2},
          1'b1, 40'h01_01_00_02_00},
        // single point frame, then a status frame whose last word keeps a single point
        '{'{OP_START_ANALOG, 12'd1, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_61_01_00_00},
        '{'{OP_ANALOG_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, -17'sd1, 17'sd5},
          1'b1, 40'h00_FE_0F_00_00},
        '{'{OP_START_STATUS, 12'd33, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'h71_F4_02_00_00},
        '{'{OP_STATUS_WORD, 12'd0, 32'h0000_0000, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'hF0_00_00_00_00},
        '{'{OP_STATUS_WORD, 12'd0, 32'h0000_0003, 32'h0000_0000, 17'sd0, 17'sd0},
          1'b1, 40'hF1_01_00_00_00}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cdt_enc_in_if  in_if  ();
    cdt_enc_cfg_if cfg_if ();
    cdt_enc_out_if out_if ();

    cdt_frame_encoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // predictor state and expected byte stream
    logic [7:0]  station_addr;
    logic [7:0]  word_idx;
    logic [11:0] pts_left;
    t_exp_byte   pending_bytes [$];

    int mismatches   = 0;
    int items_sent   = 0;
    int stall_cycles = 0;
    bit in_idle_on   = 1'b1;
    bit out_idle_on  = 1'b1;
    bit hold_output  = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // crc-8, poly 0x07, msb first, over five bytes, final inversion
    function automatic logic [7:0] check_byte(input logic [39:0] body);
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < 5; i++) begin
            crc ^= body[39 - 8 * i -: 8];
            for (int k = 0; k < 8; k++) begin
                crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            end
        end
        return crc ^ CRC_FINAL;
    endfunction

    // negative values: flag plus inverted magnitude, magnitude capped at 2047
    function automatic logic [15:0] analog_code(input logic signed [16:0] v);
        logic [16:0] mag;
        if (!v[16]) begin
            return v[15:0];
        end
        mag = -v;
        if (mag > 17'd2047) begin
            mag = 17'd2047;
        end
        return NEG_FLAG | (~mag[15:0] & NEG_MAG_MASK);
    endfunction

    // predict the bytes of one accepted item and advance the frame state
    function automatic void encode_item(input t_item it, input logic typed,
                                        input logic [39:0] typed_body);
        logic [39:0] body;
        logic [31:0] bits;
        logic [15:0] first_code;
        logic [15:0] second_code;
        logic [7:0]  nwords;
        logic        header;
        header = (it.op == OP_START_STATUS) || (it.op == OP_START_ANALOG);
        if (header) begin
            word_idx = 8'h00;
            pts_left = it.count;
            if (it.count == 12'd0) begin
                return;
            end
            nwords = (it.op == OP_START_STATUS) ? 8'((int'(it.count) + 31) / 32)
                                                : 8'((int'(it.count) + 1) / 2);
            body = {CTRL_BYTE, (it.op == OP_START_STATUS) ? TYPE_STATUS : TYPE_ANALOG,
                    nwords, station_addr, 8'h00};
        end else if (it.op == OP_STATUS_WORD) begin
            bits = it.bits ^ it.mask;
            if (pts_left < 12'd32) begin
                bits &= (32'd1 << pts_left) - 32'd1;
            end
            body = {8'(STATUS_FC_BASE + word_idx), bits[7:0], bits[15:8], bits[23:16],
                    bits[31:24]};
            pts_left -= (pts_left < 12'd32) ? pts_left : 12'd32;
            word_idx++;
        end else begin
            first_code  = (pts_left >= 12'd1) ? analog_code(it.first) : 16'h0000;
            second_code = (pts_left >= 12'd2) ? analog_code(it.second) : 16'h0000;
            body = {word_idx, first_code[7:0], first_code[15:8], second_code[7:0],
                    second_code[15:8]};
            pts_left -= (pts_left < 12'd2) ? pts_left : 12'd2;
            word_idx++;
        end
        if (typed) begin
            body = typed_body;
        end
        if (header) begin
            for (int i = 0; i < 6; i++) begin
                pending_bytes.push_back(t_exp_byte'{(i % 2 != 0) ? SYNC_B : SYNC_A, 1'b0});
            end
        end
        for (int i = 0; i < 5; i++) begin
            pending_bytes.push_back(t_exp_byte'{body[39 - 8 * i -: 8], 1'b0});
        end
        pending_bytes.push_back(t_exp_byte'{check_byte(body), 1'b1});
    endfunction

    // analog values: full span, near zero, and around the saturation edge
    function automatic logic signed [16:0] rand_analog();
        int v;
        case ($urandom_range(0, 2))
            0: begin
                v = $urandom;
            end
            1: begin
                v = int'($urandom_range(0, 4400)) - 2200;
            end
            default: begin
                v = int'($urandom_range(0, 16)) - 2056;
            end
        endcase
        return 17'(v);
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.op     = t_op'($urandom_range(0, 3));
        it.count  = 12'($urandom);
        it.bits   = $urandom;
        it.mask   = ($urandom_range(0, 1) != 0) ? 32'($urandom) : 32'h0000_0000;
        it.first  = rand_analog();
        it.second = rand_analog();
        return it;
    endfunction

    // input transfer, then prediction
    task automatic send_item(input t_item it, input logic typed, input logic [39:0] typed_body);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= it.op;
        in_if.point_count   <= it.count;
        in_if.status_bits   <= it.bits;
        in_if.invert_mask   <= it.mask;
        in_if.analog_first  <= it.first;
        in_if.analog_second <= it.second;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        encode_item(it, typed, typed_body);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [7:0] addr);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= addr;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        station_addr = addr;
    endtask

    // wait for all expected bytes, then let the block settle
    task automatic drain_and_settle(input int cycles);
        in_if.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    // one frame: start plus words, sometimes cut short or mixed, or one noise item
    task automatic send_sequence();
        t_item it;
        t_op   word_op;
        int    needed;
        int    nwords;
        it = random_item();
        if ($urandom_range(0, 9) == 0) begin
            send_item(it, 1'b0, 40'h0);
            return;
        end
        it.op = ($urandom_range(0, 1) != 0) ? OP_START_ANALOG : OP_START_STATUS;
        case ($urandom_range(0, 15))
            0: it.count = 12'd0;
            1: it.count = 12'd4095;
            2, 3: it.count = 12'($urandom_range(0, 4095));
            default: begin
                it.count = (it.op == OP_START_STATUS) ? 12'($urandom_range(1, 100))
                                                      : 12'($urandom_range(1, 12));
            end
        endcase
        send_item(it, 1'b0, 40'h0);
        needed = (it.op == OP_START_STATUS) ? (int'(it.count) + 31) / 32
                                            : (int'(it.count) + 1) / 2;
        nwords = ((needed > 12) ? 12 : needed) + $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) begin
            nwords = $urandom_range(0, nwords);
        end
        word_op = (it.op == OP_START_STATUS) ? OP_STATUS_WORD : OP_ANALOG_WORD;
        for (int w = 0; w < nwords; w++) begin
            it = random_item();
            it.op = word_op;
            if ($urandom_range(0, 9) == 0) begin
                it.op = (word_op == OP_STATUS_WORD) ? OP_ANALOG_WORD : OP_STATUS_WORD;
            end
            send_item(it, 1'b0, 40'h0);
        end
    endtask

    task automatic run_random_items(input int budget);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < budget) send_sequence();
    endtask

    // long frame so the word index wraps; the output is held off partway through
    task automatic run_long_frame();
        t_item it;
        it = random_item();
        it.op = ($urandom_range(0, 1) != 0) ? OP_START_ANALOG : OP_START_STATUS;
        it.count = 12'd4095;
        send_item(it, 1'b0, 40'h0);
        for (int w = 0; w < LONG_WORDS; w++) begin
            if (w == 20) begin
                hold_output = 1'b1;
            end
            it = random_item();
            it.op = ($urandom_range(0, 1) != 0) ? OP_ANALOG_WORD : OP_STATUS_WORD;
            send_item(it, 1'b0, 40'h0);
        end
    endtask

    // output side: random stalls, check each transfer against the oldest expectation
    initial begin : byte_sink
        int        gap;
        t_exp_byte want;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected frame_byte", out_if.frame_byte, 0);
            end else begin
                want = pending_bytes.pop_front();
                if (out_if.frame_byte !== want.value) begin
                    report_mismatch("frame_byte", out_if.frame_byte, want.value);
                end
                if (out_if.last_in_run !== want.last) begin
                    report_mismatch("last_in_run", out_if.last_in_run, want.last);
                end
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial begin : stimulus
        in_if.valid         <= 1'b0;
        in_if.operation     <= OP_START_STATUS;
        in_if.point_count   <= 12'd0;
        in_if.status_bits   <= 32'h0;
        in_if.invert_mask   <= 32'h0;
        in_if.analog_first  <= 17'sd0;
        in_if.analog_second <= 17'sd0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= 8'h00;
        station_addr = 8'h00;
        word_idx     = 8'h00;
        pts_left     = 12'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        cfg_write(8'h00);

        // directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].body);
        end

        // random phases, each with its own station address and idling mix
        for (int p = 0; p < N_PHASES; p++) begin
            drain_and_settle(SETTLE_CYCLES);
            case (p)
                0: cfg_write(8'hFF);
                3: cfg_write(8'h00);
                default: cfg_write(8'($urandom));
            endcase
            in_idle_on  = ($urandom_range(0, 2) != 0);
            out_idle_on = ($urandom_range(0, 2) != 0);
            if (p == 1) begin
                in_idle_on = 1'b0;
                run_long_frame();
            end else begin
                run_random_items(PHASE_ITEMS);
            end
        end

        drain_and_settle(END_CYCLES);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cdt_enc_pkg.sv
rtl/core/cdt_enc_in_if.sv
rtl/core/cdt_enc_out_if.sv
rtl/core/cdt_enc_cfg_if.sv
rtl/core/cdt_enc_build.sv
rtl/core/cdt_enc_serial.sv
rtl/core/cdt_frame_encoder_core.sv
verif/cdt_frame_encoder_core_tb.sv
